// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescape block.
package jsu_pkg;

	localparam int unsigned JSU_QUEUE_DEPTH = 4;
	localparam int unsigned JSU_CP_W        = 21;

	typedef struct packed {
		logic                cp_valid;
		logic [JSU_CP_W-1:0] cp;
		logic                byte_valid;
		logic [7:0]          tail_byte;
		logic                end_mark;
	} jsu_cmd_t;

endpackage

// ===== rtl/jsu_front.sv =====
// Input side: escape and surrogate state machine, turns each input byte into at most one command.
module jsu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        in_byte,
	input  logic              string_start,
	output logic              cmd_push,
	output jsu_pkg::jsu_cmd_t cmd
);
	import jsu_pkg::*;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_TAB = 8'h09;
	localparam logic [15:0] HI_FIRST = 16'hD800;
	localparam logic [15:0] HI_LAST  = 16'hDBFF;
	localparam logic [JSU_CP_W-1:0] PAIR_BIAS = 21'h02400; // 0x10000 - 0xDC00
	localparam logic [2:0] GROUP_LEN = 3'd4;

	typedef enum logic [2:0] {
		M_ENDED,
		M_TEXT,
		M_ESC,
		M_HEX_HI,
		M_WAIT_BS,
		M_WAIT_U,
		M_HEX_LO
	} mode_t;

	mode_t       mode_q, mode_e, mode_n;
	logic [15:0] acc_q, acc_e, acc_n, acc_t;
	logic [15:0] hi_q, hi_e, hi_n;
	logic [2:0]  cnt_q, cnt_e, cnt_n, cnt_t;
	logic        stop_q, stop_e, stop_n, stop_t;
	logic        is_hex, done;
	logic [3:0]  hv;
	logic        t_end, t_esc;
	logic        e_end, e_u, e_emit;
	logic [7:0]  e_byte;
	logic [JSU_CP_W-1:0] pair_cp;

	always_comb begin
		is_hex = 1'b1;
		hv     = 4'd0;
		priority if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hv = 4'(in_byte - 8'h30);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			hv = 4'(in_byte - 8'h57);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			hv = 4'(in_byte - 8'h37);
		end else begin
			is_hex = 1'b0;
		end
	end

	assign mode_e = string_start ? M_TEXT : mode_q;
	assign acc_e  = string_start ? 16'd0 : acc_q;
	assign hi_e   = string_start ? 16'd0 : hi_q;
	assign cnt_e  = string_start ? 3'd0 : cnt_q;
	assign stop_e = string_start ? 1'b0 : stop_q;

	assign acc_t  = (!stop_e && is_hex) ? {acc_e[11:0], hv} : acc_e;
	assign stop_t = stop_e | ~is_hex;
	assign cnt_t  = cnt_e + 3'd1;
	assign done   = cnt_t >= GROUP_LEN;

	assign t_end  = (in_byte == CH_NUL) || (in_byte == CH_QUOTE);
	assign t_esc  = in_byte == CH_BSL;
	assign e_end  = in_byte == CH_NUL;
	assign e_u    = in_byte == CH_U;
	assign e_emit = !e_end && !e_u && (in_byte != CH_R) && (in_byte != CH_B)
		&& (in_byte != CH_F);
	assign e_byte = (in_byte == CH_N) ? BYTE_LF : ((in_byte == CH_T) ? BYTE_TAB : in_byte);

	assign pair_cp = {1'b0, hi_e[9:0], 10'd0} + {5'd0, acc_t} + PAIR_BIAS;

	always_comb begin
		mode_n = mode_e;
		acc_n  = acc_e;
		hi_n   = hi_e;
		cnt_n  = cnt_e;
		stop_n = stop_e;
		cmd    = '0;
		unique case (mode_e)
			M_TEXT, M_WAIT_BS: begin
				if (mode_e == M_WAIT_BS && t_esc) begin
					mode_n = M_WAIT_U;
				end else begin
					if (mode_e == M_WAIT_BS) begin
						mode_n       = M_TEXT;
						cmd.cp_valid = 1'b1;
						cmd.cp       = {5'd0, hi_e};
					end
					if (t_end) begin
						cmd.end_mark = 1'b1;
						mode_n       = M_ENDED;
					end else if (t_esc) begin
						mode_n = M_ESC;
					end else begin
						cmd.byte_valid = 1'b1;
						cmd.tail_byte  = in_byte;
					end
				end
			end
			M_ESC, M_WAIT_U: begin
				if (e_u) begin
					mode_n = (mode_e == M_ESC) ? M_HEX_HI : M_HEX_LO;
					acc_n  = 16'd0;
					cnt_n  = 3'd0;
					stop_n = 1'b0;
				end else begin
					if (mode_e == M_WAIT_U) begin
						cmd.cp_valid = 1'b1;
						cmd.cp       = {5'd0, hi_e};
					end
					mode_n = M_TEXT;
					if (e_end) begin
						cmd.end_mark = 1'b1;
						mode_n       = M_ENDED;
					end else if (e_emit) begin
						cmd.byte_valid = 1'b1;
						cmd.tail_byte  = e_byte;
					end
				end
			end
			M_HEX_HI, M_HEX_LO: begin
				if (in_byte == CH_NUL) begin
					cmd.end_mark = 1'b1;
					mode_n       = M_ENDED;
				end else begin
					acc_n  = acc_t;
					cnt_n  = cnt_t;
					stop_n = stop_t;
					if (done) begin
						if (mode_e == M_HEX_HI && acc_t >= HI_FIRST && acc_t <= HI_LAST) begin
							hi_n   = acc_t;
							mode_n = M_WAIT_BS;
						end else begin
							mode_n       = M_TEXT;
							cmd.cp_valid = 1'b1;
							cmd.cp       = (mode_e == M_HEX_HI) ? {5'd0, acc_t} : pair_cp;
						end
					end
				end
			end
			default: begin
				mode_n = M_ENDED;
			end
		endcase
	end

	assign cmd_push = take && (cmd.cp_valid || cmd.byte_valid || cmd.end_mark);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_ENDED;
			acc_q  <= 16'd0;
			hi_q   <= 16'd0;
			cnt_q  <= 3'd0;
			stop_q <= 1'b0;
		end else if (take) begin
			mode_q <= mode_n;
			acc_q  <= acc_n;
			hi_q   <= hi_n;
			cnt_q  <= cnt_n;
			stop_q <= stop_n;
		end
	end

endmodule

// ===== rtl/jsu_fifo.sv =====
// Command queue between the decoder and the output serialiser.
module jsu_fifo #(
	parameter int unsigned Depth = jsu_pkg::JSU_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  jsu_pkg::jsu_cmd_t wr_data,
	input  logic              rd_en,
	output jsu_pkg::jsu_cmd_t rd_data,
	output logic              full,
	output logic              empty
);
	import jsu_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	jsu_cmd_t        mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr, do_rd;

	assign full    = count_q == CntW'(Depth);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// ===== rtl/jsu_back.sv =====
// Output side: UTF-8 encoding of a command and one result beat per cycle while pop is high.
module jsu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  jsu_pkg::jsu_cmd_t q_head,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        out_byte,
	output logic              byte_valid,
	output logic              string_end,
	output logic              last
);
	import jsu_pkg::*;

	logic [7:0] res_q [4];
	logic [7:0] lst [4];
	logic [2:0] rem_q, n;
	logic       end_q, busy_q, pop_en, ld;
	logic [JSU_CP_W-1:0] cp;

	assign cp = q_head.cp;

	always_comb begin
		lst = '{default: 8'h00};
		n   = 3'd0;
		if (q_head.cp_valid) begin
			priority if (cp < 21'h00080) begin
				lst[0] = cp[7:0];
				n      = 3'd1;
			end else if (cp < 21'h00800) begin
				lst[0] = {3'b110, cp[10:6]};
				lst[1] = {2'b10, cp[5:0]};
				n      = 3'd2;
			end else if (cp < 21'h10000) begin
				lst[0] = {4'b1110, cp[15:12]};
				lst[1] = {2'b10, cp[11:6]};
				lst[2] = {2'b10, cp[5:0]};
				n      = 3'd3;
			end else begin
				lst[0] = {5'b11110, cp[20:18]};
				lst[1] = {2'b10, cp[17:12]};
				lst[2] = {2'b10, cp[11:6]};
				lst[3] = {2'b10, cp[5:0]};
				n      = 3'd4;
			end
		end
		if (q_head.byte_valid) begin
			lst[n[1:0]] = q_head.tail_byte;
			n           = n + 3'd1;
		end
		if (q_head.end_mark) begin
			lst[n[1:0]] = 8'h00;
			n           = n + 3'd1;
		end
	end

	assign last       = rem_q == 3'd1;
	assign pop_en     = pop && busy_q;
	assign ld         = !q_empty && (!busy_q || (pop_en && last));
	assign q_pop      = ld;
	assign empty      = !busy_q;
	assign out_byte   = res_q[0];
	assign string_end = end_q && last;
	assign byte_valid = !string_end;

	always_ff @(posedge clk) begin
		if (ld) begin
			res_q <= lst;
		end else if (pop_en) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
			res_q[2] <= res_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= 3'd1;
			end_q  <= 1'b0;
		end else if (ld) begin
			busy_q <= 1'b1;
			rem_q  <= n;
			end_q  <= q_head.end_mark;
		end else if (pop_en) begin
			rem_q <= rem_q - 3'd1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescape to UTF-8 decoder.
// Input beats carry one raw byte of a JSON string body; string_start marks
// the first byte after the opening quote and clears the decoder. A beat is
// taken when push is high and full is low. Result beats come out oldest
// first while empty is low and leave when pop is high; each carries one
// UTF-8 byte or the end marker, and last flags the final beat of an input.
// The decoder takes one byte per cycle while full is low and queues each
// command in a queue of QueueDepth entries; the serialiser drains it at
// one result per cycle while pop is high, which sets the sustained rate.
// A byte's first result shows once the serialiser has loaded its command.
// A byte with no result queues nothing; one with k results gives k result
// beats. After reset the block is empty, the decoder sits in its ended
// state and bytes without string_start are dropped. When pop stays low the
// queue fills and full rises; nothing is lost or repeated.
module json_string_unescape_utf8 #(
	parameter int unsigned QueueDepth = jsu_pkg::JSU_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       string_start,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       string_end,
	output logic       last
);
	import jsu_pkg::*;

	jsu_cmd_t cmd, head;
	logic     take, cmd_push, q_empty, q_pop;

	assign take = push && !full;

	jsu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.in_byte      (in_byte),
		.string_start (string_start),
		.cmd_push     (cmd_push),
		.cmd          (cmd)
	);

	jsu_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd),
		.rd_en   (q_pop),
		.rd_data (head),
		.full    (full),
		.empty   (q_empty)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (head),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.string_end (string_end),
		.last       (last)
	);

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && string_end) |-> last)
		else $error("end marker not on final beat");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (byte_valid != string_end))
		else $error("beat is both or neither byte and end marker");

	a_burst_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last) |=> !empty)
		else $error("result burst cut short");

	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("queue full while serialiser idle");

endmodule

// ===== tb/sv/jsu_utf8_scoreboard.sv =====
// Scoreboard for the JSON string unescape block: predicts and checks result beats.
`timescale 1ns / 100ps
module jsu_utf8_scoreboard (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] in_byte,
	input  logic       string_start,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] out_byte,
	input  logic       byte_valid,
	input  logic       string_end,
	input  logic       last,
	output int         mismatches,
	output int         outstanding,
	output int         bytes_taken,
	output int         beats_checked,
	output int         strings_closed
);

	typedef enum logic [3:0] {
		DEC_ENDED,
		DEC_TEXT,
		DEC_ESC,
		DEC_HEX_HI,
		DEC_WAIT_BS,
		DEC_WAIT_U,
		DEC_HEX_LO
	} dec_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       done;
		logic       tail;
	} utf8_beat_t;

	localparam logic [7:0]  CH_NUL       = 8'h00;
	localparam logic [7:0]  CH_BSLASH    = 8'h5C;
	localparam logic [7:0]  CH_QUOTE     = 8'h22;
	localparam logic [7:0]  CH_N         = "n";
	localparam logic [7:0]  CH_T         = "t";
	localparam logic [7:0]  CH_R         = "r";
	localparam logic [7:0]  CH_B         = "b";
	localparam logic [7:0]  CH_F         = "f";
	localparam logic [7:0]  CH_U         = "u";
	localparam logic [15:0] SURR_HI_MIN  = 16'hD800;
	localparam logic [15:0] SURR_HI_MAX  = 16'hDBFF;
	localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
	localparam logic [31:0] SUPP_BASE    = 32'h10000;

	dec_mode_t  mode;
	logic [15:0] code_acc;
	logic [15:0] high_half;
	logic [2:0]  digit_cnt;
	logic        hex_halt;
	utf8_beat_t  utf8_expected[$];
	int          errs, n_in, n_out, n_ends;

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c - "0");
		if (c >= "a" && c <= "f")
			return int'(c - "a") + 10;
		if (c >= "A" && c <= "F")
			return int'(c - "A") + 10;
		return -1;
	endfunction

	task automatic reset_decoder();
		mode      = DEC_ENDED;
		code_acc  = '0;
		high_half = '0;
		digit_cnt = '0;
		hex_halt  = 1'b0;
	endtask

	task automatic add_beat(input logic [7:0] d, input logic v, input logic e);
		utf8_beat_t b;
		b = '{data: d, valid: v, done: e, tail: 1'b0};
		utf8_expected.push_back(b);
	endtask

	task automatic close_string();
		mode = DEC_ENDED;
		add_beat(CH_NUL, 1'b0, 1'b1);
	endtask

	task automatic put_code_point(input logic [31:0] cp);
		logic [31:0] lead;
		lead = cp >> 18;
		if (cp < 32'h80) begin
			add_beat(cp[7:0], 1'b1, 1'b0);
		end else if (cp < 32'h800) begin
			add_beat(8'hC0 | {3'b000, cp[10:6]}, 1'b1, 1'b0);
			add_beat(8'h80 | {2'b00, cp[5:0]}, 1'b1, 1'b0);
		end else if (cp < SUPP_BASE) begin
			add_beat(8'hE0 | {4'h0, cp[15:12]}, 1'b1, 1'b0);
			add_beat(8'h80 | {2'b00, cp[11:6]}, 1'b1, 1'b0);
			add_beat(8'h80 | {2'b00, cp[5:0]}, 1'b1, 1'b0);
		end else begin
			add_beat(8'hF0 | lead[7:0], 1'b1, 1'b0);
			add_beat(8'h80 | {2'b00, cp[17:12]}, 1'b1, 1'b0);
			add_beat(8'h80 | {2'b00, cp[11:6]}, 1'b1, 1'b0);
			add_beat(8'h80 | {2'b00, cp[5:0]}, 1'b1, 1'b0);
		end
	endtask

	task automatic open_group(input dec_mode_t m);
		mode      = m;
		code_acc  = '0;
		digit_cnt = '0;
		hex_halt  = 1'b0;
	endtask

	// one hex position; value freezes at the first non-hex digit
	task automatic take_hex(input logic [7:0] c, output bit done);
		int v;
		v = hex_nibble(c);
		if (!hex_halt && v >= 0)
			code_acc = {code_acc[11:0], v[3:0]};
		else
			hex_halt = 1'b1;
		digit_cnt = digit_cnt + 3'd1;
		done = (digit_cnt >= 3'd4);
	endtask

	task automatic plain_byte(input logic [7:0] c);
		if (c == CH_NUL || c == CH_QUOTE)
			close_string();
		else if (c == CH_BSLASH)
			mode = DEC_ESC;
		else
			add_beat(c, 1'b1, 1'b0);
	endtask

	task automatic escaped_byte(input logic [7:0] c);
		mode = DEC_TEXT;
		case (c)
			CH_NUL: close_string();
			CH_N: add_beat(8'h0A, 1'b1, 1'b0);
			CH_T: add_beat(8'h09, 1'b1, 1'b0);
			CH_R, CH_B, CH_F: ;
			CH_U: open_group(DEC_HEX_HI);
			default: add_beat(c, 1'b1, 1'b0);
		endcase
	endtask

	task automatic decode_byte(input logic [7:0] c, input logic st);
		bit          done;
		logic [31:0] cp;
		int          first;
		utf8_beat_t  b;
		first = utf8_expected.size();
		if (st) begin
			reset_decoder();
			mode = DEC_TEXT;
		end
		case (mode)
			DEC_TEXT: plain_byte(c);
			DEC_ESC: escaped_byte(c);
			DEC_HEX_HI: begin
				if (c == CH_NUL) begin
					close_string();
				end else begin
					take_hex(c, done);
					if (done) begin
						if (code_acc >= SURR_HI_MIN && code_acc <= SURR_HI_MAX) begin
							high_half = code_acc;
							mode = DEC_WAIT_BS;
						end else begin
							mode = DEC_TEXT;
							put_code_point({16'h0, code_acc});
						end
					end
				end
			end
			DEC_WAIT_BS: begin
				if (c == CH_BSLASH) begin
					mode = DEC_WAIT_U;
				end else begin
					mode = DEC_TEXT;
					put_code_point({16'h0, high_half});
					plain_byte(c);
				end
			end
			DEC_WAIT_U: begin
				if (c == CH_U) begin
					open_group(DEC_HEX_LO);
				end else begin
					put_code_point({16'h0, high_half});
					escaped_byte(c);
				end
			end
			DEC_HEX_LO: begin
				if (c == CH_NUL) begin
					close_string();
				end else begin
					take_hex(c, done);
					if (done) begin
						// low half taken as is, no range check
						cp = SUPP_BASE + (({16'h0, high_half} - {16'h0, SURR_HI_MIN}) << 10)
							+ {16'h0, code_acc} - {16'h0, SURR_LO_BASE};
						mode = DEC_TEXT;
						put_code_point(cp);
					end
				end
			end
			default: mode = DEC_ENDED;
		endcase
		if (utf8_expected.size() > first) begin
			b = utf8_expected.pop_back();
			b.tail = 1'b1;
			utf8_expected.push_back(b);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			errs++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	task automatic check_beat();
		utf8_beat_t want;
		if (utf8_expected.size() == 0) begin
			errs++;
			$display("%0t: result beat with nothing expected, out_byte=%h byte_valid=%b string_end=%b last=%b",
				$time, out_byte, byte_valid, string_end, last);
		end else begin
			want = utf8_expected.pop_front();
			check_field("out_byte", want.data, out_byte);
			check_field("byte_valid", 8'(want.valid), 8'(byte_valid));
			check_field("string_end", 8'(want.done), 8'(string_end));
			check_field("last", 8'(want.tail), 8'(last));
			n_out++;
			if (want.done)
				n_ends++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_decoder();
			utf8_expected.delete();
			errs   = 0;
			n_in   = 0;
			n_out  = 0;
			n_ends = 0;
			mismatches     <= 0;
			outstanding    <= 0;
			bytes_taken    <= 0;
			beats_checked  <= 0;
			strings_closed <= 0;
		end else begin
			// a beat leaving now cannot stem from a byte taken at this edge
			if (pop && !empty)
				check_beat();
			if (push && !full) begin
				decode_byte(in_byte, string_start);
				n_in++;
			end
			mismatches     <= errs;
			outstanding    <= utf8_expected.size();
			bytes_taken    <= n_in;
			beats_checked  <= n_out;
			strings_closed <= n_ends;
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the JSON string unescape testbench: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module testbench;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam int ITEM_TARGET = 320;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_U      = "u";

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       push         = 1'b0;
	logic [7:0] in_byte      = 8'h00;
	logic       string_start = 1'b0;
	logic       pop          = 1'b0;
	logic       full, empty;
	logic [7:0] out_byte;
	logic       byte_valid, string_end, last;

	int mismatches, outstanding, bytes_taken, beats_checked, strings_closed;
	int wd_cycles = 0;
	int items_sent = 0;
	int pairs_sent = 0;
	bit steady = 1'b0;
	bit start_pending = 1'b0;
	bit string_closed = 1'b0;

	json_string_unescape_utf8 u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_byte      (in_byte),
		.string_start (string_start),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.string_end   (string_end),
		.last         (last)
	);

	jsu_utf8_scoreboard u_scoreboard (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.in_byte        (in_byte),
		.string_start   (string_start),
		.empty          (empty),
		.pop            (pop),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.string_end     (string_end),
		.last           (last),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.bytes_taken    (bytes_taken),
		.beats_checked  (beats_checked),
		.strings_closed (strings_closed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= steady || ($urandom_range(0, 99) >= 13);
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			wd_cycles <= 0;
		else
			wd_cycles <= wd_cycles + 1;
		if (wd_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, wd_cycles);
			$display("FAIL json_string_unescape_utf8");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit st);
		while (!steady && $urandom_range(0, 99) < 13) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		in_byte      <= b;
		string_start <= st;
		do @(posedge clk); while (full);
	endtask

	task automatic send_item(input logic [7:0] b);
		send_byte(b, start_pending);
		start_pending = 1'b0;
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i]);
	endtask

	// hold the sender until every pending beat has come out
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return "0" + n;
		return ($urandom_range(0, 1) ? "a" : "A") + n - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex();
		case ($urandom_range(0, 5))
			0: return CH_QUOTE;
			1: return "g";
			2: return " ";
			3: return "x";
			4: return 8'hFF;
			default: return "-";
		endcase
	endfunction

	function automatic logic [7:0] pick_escape();
		logic [7:0] c;
		case ($urandom_range(0, 8))
			0: c = "n";
			1: c = "t";
			2: c = "r";
			3: c = "b";
			4: c = "f";
			5: c = CH_QUOTE;
			6: c = CH_BSLASH;
			7: c = "/";
			default: begin
				c = 8'($urandom_range(1, 255));
				if (c == CH_U)
					c = "v";
			end
		endcase
		return c;
	endfunction

	function automatic logic [15:0] bmp_value();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'h007F;
			2: return 16'h0080;
			3: return 16'h07FF;
			4: return 16'h0800;
			5: return 16'hFFFF;
			6: return 16'($urandom_range(0, 16'h7F));
			7: return 16'($urandom_range(16'h80, 16'h7FF));
			default: return 16'($urandom_range(16'h800, 16'hFFFF));
		endcase
	endfunction

	function automatic logic [15:0] high_surrogate();
		return 16'hD800 + 16'($urandom_range(0, 16'h3FF));
	endfunction

	function automatic logic [15:0] low_surrogate();
		if ($urandom_range(0, 9) < 7)
			return 16'hDC00 + 16'($urandom_range(0, 16'h3FF));
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	task automatic send_hex_group(input logic [15:0] v, input bit broken);
		int bad;
		bad = broken ? $urandom_range(0, 3) : -1;
		for (int i = 3; i >= 0; i--) begin
			if (i == bad)
				send_item(non_hex());
			else
				send_item(hex_char(v[i*4 +: 4]));
		end
	endtask

	task automatic send_unicode();
		send_item(CH_BSLASH);
		send_item(CH_U);
		case ($urandom_range(0, 9))
			0, 1, 2: send_hex_group(bmp_value(), 1'b0);
			3, 4: begin
				send_hex_group(high_surrogate(), 1'b0);
				send_item(CH_BSLASH);
				send_item(CH_U);
				send_hex_group(low_surrogate(), $urandom_range(0, 4) == 0);
				pairs_sent++;
			end
			5: begin
				send_hex_group(high_surrogate(), 1'b0);
				if ($urandom_range(0, 2) == 0) begin
					send_item(CH_QUOTE);
					string_closed = 1'b1;
				end
			end
			6: begin
				send_hex_group(high_surrogate(), 1'b0);
				send_item(CH_BSLASH);
				if ($urandom_range(0, 3) == 0) begin
					send_item(CH_NUL);
					string_closed = 1'b1;
				end else begin
					send_item(pick_escape());
				end
			end
			7: send_hex_group(16'($urandom_range(0, 16'hFFFF)), 1'b1);
			8: begin
				if ($urandom_range(0, 1)) begin
					send_hex_group(high_surrogate(), 1'b0);
					send_item(CH_BSLASH);
					send_item(CH_U);
				end
				repeat ($urandom_range(0, 3))
					send_item(hex_char(4'($urandom_range(0, 15))));
				send_item(CH_NUL);
				string_closed = 1'b1;
			end
			default: send_hex_group(16'hDC00 + 16'($urandom_range(0, 16'h3FF)), 1'b0);
		endcase
	endtask

	task automatic send_random_string();
		int         ntok;
		int         r;
		logic [7:0] c;
		start_pending = 1'b1;
		string_closed = 1'b0;
		ntok = $urandom_range(0, 10);
		for (int k = 0; k < ntok && !string_closed; k++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				c = 8'($urandom_range(1, 255));
				if (c == CH_BSLASH || c == CH_QUOTE)
					c = "a";
				send_item(c);
			end else if (r < 58) begin
				send_item(CH_BSLASH);
				send_item(pick_escape());
			end else if (r < 93) begin
				send_unicode();
			end else if (r < 95) begin
				send_item(CH_BSLASH);
				send_item(CH_NUL);
				string_closed = 1'b1;
			end else begin
				send_byte(8'($urandom_range(0, 255)), start_pending | 1'($urandom_range(0, 1)));
				start_pending = 1'b0;
				items_sent++;
			end
		end
		if (!string_closed)
			send_item(($urandom_range(0, 9) < 8) ? CH_QUOTE : CH_NUL);
		start_pending = 1'b0;
		// bytes between strings are dropped by the block
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// dropped before the first start
		send_byte("q", 1'b0);
		start_pending = 1'b1;
		send_item(8'hFF);
		// largest combined pair, then escaped zero
		send_text("\\n\\r\\uDBFF\\uFFFF\\");
		send_item(CH_NUL);
		send_byte("z", 1'b0);
		// quote inside hex digits, zero inside hex digits
		start_pending = 1'b1;
		send_text("\\u0\"12\\u00");
		send_item(CH_NUL);
		drain();

		while (items_sent < ITEM_TARGET / 2)
			send_random_string();
		drain();
		steady = 1'b1;
		while (items_sent < (ITEM_TARGET * 3) / 4)
			send_random_string();
		steady = 1'b0;
		while (items_sent < ITEM_TARGET)
			send_random_string();

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d input beats in %0d strings, %0d surrogate pairs among them",
			bytes_taken, strings_closed, pairs_sent);
		$display("%0d result beats checked, %0d mismatches, %0d still expected",
			beats_checked, mismatches, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS json_string_unescape_utf8");
		else
			$display("FAIL json_string_unescape_utf8");
		$finish;
	end

endmodule
